// ----- rtl/core/sfpr_pkg.sv -----
// Shared types and constants for the segmented FIFO page replacement block.
// No dependencies.
package sfpr_pkg;
  localparam int MaxFrames = 64;
  localparam int PageShift = 12;
  localparam int PageW = 32 - PageShift;
  localparam int IdxW = $clog2(MaxFrames);
  localparam int CntW = IdxW + 1;
  localparam int CfgW = 7;
  localparam int PctMax = 100;

  localparam logic CfgFrames = 1'b0;
  localparam logic CfgPercent = 1'b1;

  typedef enum logic [1:0] {
    PlaceMiss = 2'd0,
    PlaceFifo = 2'd1,
    PlaceLru  = 2'd2
  } place_e;

  typedef enum logic [1:0] {
    StIdle,
    StApply,
    StOut
  } state_e;

  typedef struct packed {
    logic [PageW-1:0] page;
    logic             dirty;
  } slot_t;

  typedef struct packed {
    logic look;
    logic apply;
  } cmd_t;

  typedef struct packed {
    place_e           place;
    logic             dread;
    logic             dwrite;
    logic [PageW-1:0] evp;
    logic             ev;
    logic [31:0]      rtot;
    logic [31:0]      wtot;
  } res_t;
endpackage

// ----- rtl/core/sfpr_if.sv -----
// Valid/ready channel interface with source and sink views.
// Depends on nothing; the payload width is set at instantiation.
interface sfpr_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sfpr_ctrl.sv -----
// Controller state machine: accepts an access, sequences lookup and update.
// Depends on sfpr_pkg.
module sfpr_ctrl import sfpr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output cmd_t   cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.look = 1'b1;
          state_d = StApply;
        end
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        in_ready_o = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.look = 1'b1;
            state_d = StApply;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// ----- rtl/core/sfpr_dp.sv -----
// Datapath: two shift-register segments with per-entry compare, counters.
// Depends on sfpr_pkg.
module sfpr_dp import sfpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [31:0]      addr_i,
  input  logic             wr_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  output res_t             res_o
);
  slot_t fifo_q [MaxFrames];
  slot_t lru_q [MaxFrames];
  logic [CntW-1:0] fcnt_q, lcnt_q;
  logic [31:0] rcnt_q, wcnt_q;
  logic [CfgW-1:0] frames_q, pct_q;
  logic [PageW-1:0] page_q;
  logic wr_q;
  logic [MaxFrames-1:0] fhit_q, lhit_q;
  logic [CntW-1:0] fmax_q, lmax_q;
  res_t res_q;

  // Capacity: frames * pct / 100 via reciprocal multiply (x*5243>>19 exact for x<=6400).
  logic [CfgW-1:0] frames_c, pct_c;
  logic [12:0] prod_c;
  logic [25:0] quo_c;
  always_comb begin
    frames_c = frames_q;
    if (frames_q == '0) frames_c = CfgW'(1);
    if (frames_q > CfgW'(MaxFrames)) frames_c = CfgW'(MaxFrames);
    pct_c = (pct_q > CfgW'(PctMax)) ? CfgW'(PctMax) : pct_q;
    prod_c = 13'(frames_c) * 13'(pct_c);
    quo_c = 26'(prod_c) * 26'd5243;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= CfgW'(MaxFrames);
      pct_q <= CfgW'(50);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgFrames) frames_q <= cfg_data_i;
      else pct_q <= cfg_data_i;
    end
  end

  // Lookup stage: per-entry compare.
  logic [PageW-1:0] page_c;
  assign page_c = addr_i[31:PageShift];
  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      page_q <= page_c;
      wr_q <= wr_i;
      fmax_q <= CntW'(quo_c[25:19]);
      lmax_q <= CntW'(frames_c) - CntW'(quo_c[25:19]);
      for (int i = 0; i < MaxFrames; i++) begin
        fhit_q[i] <= (fifo_q[i].page == page_c) && (CntW'(i) < fcnt_q);
        lhit_q[i] <= (lru_q[i].page == page_c) && (CntW'(i) < lcnt_q);
      end
    end
  end

  // Apply stage: decide operations and shift each cell locally.
  logic [IdxW-1:0] lidx, fidx;
  logic lfound, ffound;
  always_comb begin
    lidx = '0;
    fidx = '0;
    lfound = |lhit_q;
    ffound = |fhit_q;
    for (int i = MaxFrames - 1; i >= 0; i--) begin
      if (lhit_q[i]) lidx = IdxW'(i);
      if (fhit_q[i]) fidx = IdxW'(i);
    end
  end

  logic l_rm, l_push, f_pop, f_push, f_dirty;
  logic [CntW-1:0] l_rm_idx;
  slot_t l_new, f_new, victim_c, nw_c;
  logic ev_c;
  always_comb begin
    l_rm = 1'b0; l_push = 1'b0; f_pop = 1'b0; f_push = 1'b0; f_dirty = 1'b0;
    l_rm_idx = '0; l_new = '0; f_new = '0; victim_c = '0; ev_c = 1'b0;
    nw_c.page = page_q;
    nw_c.dirty = wr_q;
    if (lfound) begin
      l_rm = 1'b1;
      l_rm_idx = CntW'(lidx);
      if (fcnt_q == '0) begin
        l_push = 1'b1;
        l_new = lru_q[lidx];
        l_new.dirty = lru_q[lidx].dirty | wr_q;
      end else begin
        f_pop = 1'b1; f_push = 1'b1; l_push = 1'b1;
        f_new = lru_q[lidx];
        f_new.dirty = lru_q[lidx].dirty | wr_q;
        l_new = fifo_q[0];
      end
    end else if (ffound) begin
      f_dirty = wr_q;
    end else if (fcnt_q < fmax_q) begin
      f_push = 1'b1; f_new = nw_c;
    end else if (fcnt_q == '0) begin
      if (lcnt_q >= lmax_q && lcnt_q != '0) begin
        l_rm = 1'b1; l_rm_idx = lcnt_q - CntW'(1);
        ev_c = 1'b1; victim_c = lru_q[l_rm_idx[IdxW-1:0]];
      end
      l_push = 1'b1; l_new = nw_c;
    end else if (lcnt_q < lmax_q) begin
      f_pop = 1'b1; f_push = 1'b1; l_push = 1'b1;
      l_new = fifo_q[0]; f_new = nw_c;
    end else if (lcnt_q == '0) begin
      f_pop = 1'b1; f_push = 1'b1; f_new = nw_c;
      ev_c = 1'b1; victim_c = fifo_q[0];
    end else begin
      l_rm = 1'b1; l_rm_idx = lcnt_q - CntW'(1);
      ev_c = 1'b1; victim_c = lru_q[l_rm_idx[IdxW-1:0]];
      f_pop = 1'b1; f_push = 1'b1; l_push = 1'b1;
      l_new = fifo_q[0]; f_new = nw_c;
    end
  end

  logic [CntW-1:0] lc_mid, fc_mid, ftail;
  assign lc_mid = l_rm ? lcnt_q - CntW'(1) : lcnt_q;
  assign fc_mid = f_pop ? fcnt_q - CntW'(1) : fcnt_q;
  assign ftail = fc_mid;

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      for (int i = 0; i < MaxFrames; i++) begin
        // LRU: remove at l_rm_idx (shift up from above), then push at head.
        // With both, cells past the removed one end where they started.
        slot_t after_rm;
        after_rm = lru_q[i];
        if (l_rm && CntW'(i) >= l_rm_idx && i < MaxFrames - 1) after_rm = lru_q[i + 1];
        if (l_push && lc_mid < CntW'(MaxFrames)) begin
          if (i == 0) lru_q[i] <= l_new;
          else if (CntW'(i) <= l_rm_idx || !l_rm) lru_q[i] <= lru_q[i - 1];
          else lru_q[i] <= lru_q[i];
        end else begin
          lru_q[i] <= after_rm;
        end
        // FIFO: pop head (shift down), then write tail.
        if (f_push && CntW'(i) == ftail && ftail < CntW'(MaxFrames)) fifo_q[i] <= f_new;
        else if (f_pop && i < MaxFrames - 1) fifo_q[i] <= fifo_q[i + 1];
        else if (f_dirty && IdxW'(i) == fidx) fifo_q[i].dirty <= 1'b1;
      end
    end
  end

  logic dw_c;
  assign dw_c = ev_c & victim_c.dirty;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0; lcnt_q <= '0; rcnt_q <= '0; wcnt_q <= '0;
    end else if (cmd_i.apply) begin
      fcnt_q <= (f_push && fc_mid < CntW'(MaxFrames)) ? fc_mid + CntW'(1) : fc_mid;
      lcnt_q <= (l_push && lc_mid < CntW'(MaxFrames)) ? lc_mid + CntW'(1) : lc_mid;
      if (!lfound && !ffound && rcnt_q != '1) rcnt_q <= rcnt_q + 32'd1;
      if (dw_c && wcnt_q != '1) wcnt_q <= wcnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      res_q.place <= lfound ? PlaceLru : (ffound ? PlaceFifo : PlaceMiss);
      res_q.dread <= !lfound && !ffound;
      res_q.dwrite <= dw_c;
      res_q.ev <= ev_c;
      res_q.evp <= ev_c ? victim_c.page : '0;
      res_q.rtot <= (!lfound && !ffound && rcnt_q != '1) ? rcnt_q + 32'd1 : rcnt_q;
      res_q.wtot <= (dw_c && wcnt_q != '1) ? wcnt_q + 32'd1 : wcnt_q;
    end
  end
  assign res_o = res_q;
endmodule

// ----- rtl/core/segmented_fifo_page_replacement.sv -----
// Top level of the segmented FIFO page replacement block.
// Depends on sfpr_pkg, sfpr_if, sfpr_ctrl and sfpr_dp.
//
//   channel  direction  payload
//   in_if    sink       virtual_address[31:0], is_write
//   out_if   source     hit_place, disk_read, disk_write, evicted_page,
//                       evict_valid, read_total, write_total
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i[6:0]
//
// Each access is looked up, comparing the page against every resident cell
// of both segments, then applied, shifting segments and updating counters.
// The result is held in a register until its transfer completes; the next
// access is taken in the same cycle the result leaves. A stalled output holds
// the block. Reset clears counters and returns registers to 64 frames, 50%.
module segmented_fifo_page_replacement import sfpr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  sfpr_if.sink            in_if,
  sfpr_if.source          out_if,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);
  cmd_t cmd;
  res_t res;

  // Writes to indexes past the register list are dropped.
  logic cfg_we;
  assign cfg_we = cfg_we_i && (cfg_idx_i[1] == 1'b0);

  sfpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd)
  );

  sfpr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .addr_i     (in_if.data[32:1]),
    .wr_i       (in_if.data[0]),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx_i[0]),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  // Output payload: {hit_place, disk_read, disk_write, evicted_page,
  // evict_valid, read_total, write_total}.
  assign out_if.data = {res.place, res.dread, res.dwrite, res.evp, res.ev,
                        res.rtot, res.wtot};
endmodule

// ----- verif/sfpr_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the segmented FIFO page replacement block: it mirrors the frame
// state, predicts each result and compares transfers. Depends on sfpr_pkg and sfpr_if.
module sfpr_checker import sfpr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  sfpr_if                 in_mon,
  sfpr_if                 out_mon,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int              pending_o,
  output int              errors_o
);
  slot_t       fifo_q [MaxFrames];
  slot_t       lru_q [MaxFrames];
  int          fifo_cnt, lru_cnt;
  logic [31:0] reads, writes;
  logic [6:0]  frames_reg, pct_reg;
  res_t        expected_q [$];

  function automatic slot_t fifo_pop();
    slot_t h;
    h = fifo_q[0];
    for (int i = 1; i < fifo_cnt; i++) fifo_q[i-1] = fifo_q[i];
    fifo_cnt--;
    return h;
  endfunction

  function automatic void fifo_push(slot_t e);
    if (fifo_cnt < MaxFrames) begin
      fifo_q[fifo_cnt] = e;
      fifo_cnt++;
    end
  endfunction

  function automatic slot_t lru_take(int idx);
    slot_t e;
    e = lru_q[idx];
    for (int i = idx + 1; i < lru_cnt; i++) lru_q[i-1] = lru_q[i];
    lru_cnt--;
    return e;
  endfunction

  function automatic void lru_head(slot_t e);
    if (lru_cnt >= MaxFrames) return;
    for (int i = lru_cnt; i > 0; i--) lru_q[i] = lru_q[i-1];
    lru_q[0] = e;
    lru_cnt++;
  endfunction

  function automatic res_t predict_access(logic [31:0] addr, logic wr);
    res_t  r;
    slot_t e, h, nw, victim;
    logic [PageW-1:0] page;
    int    frames, pct, fmax, lmax;
    logic  found;
    page   = addr[31:PageShift];
    frames = (frames_reg == 0) ? 1 : (frames_reg > MaxFrames) ? MaxFrames : frames_reg;
    pct    = (pct_reg > PctMax) ? PctMax : pct_reg;
    fmax   = frames * pct / PctMax;
    lmax   = frames - fmax;
    r      = '0;
    r.place = PlaceMiss;
    found  = 1'b0;
    for (int i = 0; i < lru_cnt && !found; i++) begin
      if (lru_q[i].page == page) begin
        e = lru_take(i);
        found = 1'b1;
        r.place = PlaceLru;
        if (wr) e.dirty = 1'b1;
        if (fifo_cnt == 0) begin
          lru_head(e);
        end else begin
          h = fifo_pop();
          fifo_push(e);
          lru_head(h);
        end
      end
    end
    for (int i = 0; i < fifo_cnt && !found; i++) begin
      if (fifo_q[i].page == page) begin
        found = 1'b1;
        r.place = PlaceFifo;
        if (wr) fifo_q[i].dirty = 1'b1;
      end
    end
    if (!found) begin
      r.dread = 1'b1;
      if (reads != '1) reads++;
      nw.page  = page;
      nw.dirty = wr;
      if (fifo_cnt < fmax) begin
        fifo_push(nw);
      end else if (fifo_cnt == 0) begin
        // With no FIFO share the LRU segment works alone.
        if (lru_cnt >= lmax && lru_cnt > 0) begin
          victim = lru_take(lru_cnt - 1);
          r.ev = 1'b1; r.evp = victim.page; r.dwrite = victim.dirty;
        end
        lru_head(nw);
      end else if (lru_cnt < lmax) begin
        lru_head(fifo_pop());
        fifo_push(nw);
      end else if (lru_cnt == 0) begin
        // With no LRU share the FIFO head leaves memory directly.
        victim = fifo_pop();
        r.ev = 1'b1; r.evp = victim.page; r.dwrite = victim.dirty;
        fifo_push(nw);
      end else begin
        victim = lru_take(lru_cnt - 1);
        r.ev = 1'b1; r.evp = victim.page; r.dwrite = victim.dirty;
        lru_head(fifo_pop());
        fifo_push(nw);
      end
      if (r.dwrite && writes != '1) writes++;
    end
    r.rtot = reads;
    r.wtot = writes;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      fifo_cnt   = 0;
      lru_cnt    = 0;
      reads      = '0;
      writes     = '0;
      frames_reg = 7'd64;
      pct_reg    = 7'd50;
      expected_q.delete();
      errors_o   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == 2'(CfgFrames)) frames_reg = cfg_data_i;
        else if (cfg_idx_i == 2'(CfgPercent)) pct_reg = cfg_data_i;
      end
      // The result leaving now belongs to an earlier access, so take it first.
      if (out_mon.valid && out_mon.ready) begin
        got = res_t'(out_mon.data);
        if (expected_q.size() == 0) begin
          $error("result transfer with no access outstanding");
          errors_o++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          check_field("hit_place", want.place, got.place);
          check_field("disk_read", want.dread, got.dread);
          check_field("disk_write", want.dwrite, got.dwrite);
          check_field("evicted_page", want.evp, got.evp);
          check_field("evict_valid", want.ev, got.ev);
          check_field("read_total", want.rtot, got.rtot);
          check_field("write_total", want.wtot, got.wtot);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.insert(expected_q.size(),
                          predict_access(in_mon.data[32:1], in_mon.data[0]));
    end
    pending_o = expected_q.size();
  end
endmodule

// ----- verif/segmented_fifo_page_replacement_tb.sv -----
`timescale 1ns / 100ps
// Top of the page replacement testbench: clock, reset, access and configuration
// stimulus, result back-pressure and the verdict. Depends on sfpr_pkg, sfpr_if, sfpr_checker.
module segmented_fifo_page_replacement_tb;
  import sfpr_pkg::*;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [1:0]      cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  int              pending, errors;
  int              cyc;
  logic            calm;

  // Access payload is {virtual_address, is_write}; the result is a packed res_t.
  sfpr_if #(.W(33))           acc_ch ();
  sfpr_if #(.W($bits(res_t))) res_ch ();

  segmented_fifo_page_replacement DUT (
    .clk_i, .rst_ni, .in_if(acc_ch), .out_if(res_ch),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  sfpr_checker u_checker (
    .clk_i, .rst_ni, .in_mon(acc_ch), .out_mon(res_ch),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // The result side counts cycles and owns the back-pressure. Early on it holds
  // ready low for a long stretch so the block fills up and stalls its input; later
  // there is a window where neither side idles.
  initial begin
    cyc = 0;
    calm = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      calm = (cyc >= 1200 && cyc < 1700);
      if (cyc >= 600 && cyc < 900) res_ch.ready <= 1'b0;
      else res_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  // Offer one access and return on the falling edge after its transfer.
  // Valid stays high so back-to-back accesses need only one assignment per step.
  task automatic send_access(input logic [31:0] addr, input logic wr);
    while (!calm && $urandom_range(0, 99) < 11) begin
      acc_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    acc_ch.valid <= 1'b1;
    acc_ch.data  <= {addr, wr};
    @(posedge clk_i);
    while (!acc_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Registers are only written with nothing in flight; extra idle waiting after
  // the last result covers the access pipeline.
  task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] val);
    acc_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random accesses drawn mostly from a small page working set so that hits in
  // both segments, promotions and evictions are all frequent.
  task automatic run_phase(input int n_items, input int set_size);
    logic [PageW-1:0] pages [];
    logic [31:0]      addr;
    pages = new[set_size];
    foreach (pages[i]) pages[i] = PageW'($urandom);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 85)
        addr = {pages[$urandom_range(0, set_size - 1)], 12'($urandom)};
      else
        addr = $urandom;
      send_access(addr, 1'($urandom_range(0, 1)));
    end
  endtask

  logic [6:0] frames_set [10] = '{7'd1, 7'd1, 7'd0, 7'd127, 7'd64, 7'd64,
                                  7'd8, 7'd10, 7'd5, 7'd3};
  logic [6:0] pct_set [10]    = '{7'd0, 7'd100, 7'd50, 7'd100, 7'd0, 7'd100,
                                  7'd127, 7'd33, 7'd50, 7'd67};

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    acc_ch.valid = 1'b0;
    acc_ch.data  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset setting of 64 frames, half FIFO: address
    // extremes, a FIFO hit with a write, then misses that still fit the FIFO share.
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'h0000_0FFF, 1'b1);
    send_access(32'hFFFF_F000, 1'b0);
    for (int k = 1; k <= 33; k += 4) send_access({20'(k), 12'h0}, k[2]);
    send_access(32'h0000_0000, 1'b1);

    // Tiny memory, empty FIFO share: old FIFO pages still feed LRU, with dirty evictions.
    write_reg(2'(CfgFrames), 7'd2);
    write_reg(2'(CfgPercent), 7'd0);
    send_access(32'h0000_1000, 1'b1);
    send_access(32'h0000_2000, 1'b0);
    send_access(32'h0000_1000, 1'b0);
    send_access(32'h0000_3000, 1'b1);
    send_access(32'h0000_4000, 1'b0);
    // Shrinking the LRU share to nothing keeps its leftover pages, which misses still evict.
    write_reg(2'(CfgPercent), 7'd100);
    send_access(32'h0000_5000, 1'b1);
    send_access(32'h0000_6000, 1'b0);
    send_access(32'h0000_3000, 1'b0);
    send_access(32'h0000_7000, 1'b1);
    send_access(32'h0000_8000, 1'b0);

    // Random part across several settings; contents carry over between them.
    foreach (frames_set[p]) begin
      write_reg(2'(CfgFrames), frames_set[p]);
      write_reg(2'(CfgPercent), pct_set[p]);
      run_phase(62, (frames_set[p] == 0 ? 1 : frames_set[p] > 64 ? 64 : frames_set[p]) + 3);
    end
    acc_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/sfpr_pkg.sv
rtl/core/sfpr_if.sv
rtl/core/sfpr_ctrl.sv
rtl/core/sfpr_dp.sv
rtl/core/segmented_fifo_page_replacement.sv
verif/sfpr_checker.sv
verif/segmented_fifo_page_replacement_tb.sv
